### rtl/running_rmse_four_lanes_unit_macros.svh
// Assertion macros shared by the running RMSE unit's checker.
// No dependencies; included by files that assert.
`ifndef RUNNING_RMSE_FOUR_LANES_UNIT_MACROS_SVH
`define RUNNING_RMSE_FOUR_LANES_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RRMSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrmse assertion failed");

// Next-cycle implication, disabled in reset.
`define RRMSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrmse assertion failed");

`endif

### rtl/rrmse_pkg.sv
// Package for the running RMSE unit: widths, reset tolerances, beat types.
// No dependencies; used by every module of the unit.
`default_nettype none
package rrmse_pkg;

    localparam int LANES           = 4;
    localparam int LANE_W          = 2;
    localparam int DATA_W          = 32;
    localparam int SUM_W           = 64;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int STEP_W          = 6;
    localparam int DIV_STEPS       = 64;
    localparam int ROOT_STEPS      = 32;

    // Q16.16 reset tolerances: 0.09, 0.10, 0.40, 0.30
    localparam logic [DATA_W-1:0] TOL_RESET [LANES] = '{
        32'd5898, 32'd6554, 32'd26214, 32'd19661
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOL_LANE0,
        CFG_TOL_LANE1,
        CFG_TOL_LANE2,
        CFG_TOL_LANE3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] est_0;
        logic signed [DATA_W-1:0] est_1;
        logic signed [DATA_W-1:0] est_2;
        logic signed [DATA_W-1:0] est_3;
        logic signed [DATA_W-1:0] truth_0;
        logic signed [DATA_W-1:0] truth_1;
        logic signed [DATA_W-1:0] truth_2;
        logic signed [DATA_W-1:0] truth_3;
    } t_in_beat;

    typedef struct packed {
        logic [DATA_W-1:0] rmse_0;
        logic [DATA_W-1:0] rmse_1;
        logic [DATA_W-1:0] rmse_2;
        logic [DATA_W-1:0] rmse_3;
        logic [LANES-1:0]  over_mask;
        logic [DATA_W-1:0] step_count;
    } t_out_beat;

    // Per-lane |est - truth|, queued between front and back
    typedef struct packed {
        logic [LANES-1:0][DATA_W-1:0] mag;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_ACCUM,
        BK_DIVIDE,
        BK_ROOT,
        BK_EMIT
    } t_back_state;

endpackage
`default_nettype wire

### rtl/rrmse_front.sv
// Front end: accepts input beats and reduces them to per-lane magnitudes.
// Depends on rrmse_pkg.
`default_nettype none
module rrmse_front (
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  rrmse_pkg::t_in_beat      i_in_data,
    input  rrmse_pkg::t_q_status     i_q_status,
    output logic                     o_push,
    output rrmse_pkg::t_work         o_push_data
);

    logic signed [rrmse_pkg::DATA_W-1:0] est   [rrmse_pkg::LANES];
    logic signed [rrmse_pkg::DATA_W-1:0] truth [rrmse_pkg::LANES];
    logic signed [rrmse_pkg::DATA_W:0]   diff  [rrmse_pkg::LANES];
    logic        [rrmse_pkg::DATA_W:0]   neg   [rrmse_pkg::LANES];

    assign est[0]   = i_in_data.est_0;
    assign est[1]   = i_in_data.est_1;
    assign est[2]   = i_in_data.est_2;
    assign est[3]   = i_in_data.est_3;
    assign truth[0] = i_in_data.truth_0;
    assign truth[1] = i_in_data.truth_1;
    assign truth[2] = i_in_data.truth_2;
    assign truth[3] = i_in_data.truth_3;

    always_comb begin
        for (int i = 0; i < rrmse_pkg::LANES; i++) begin
            diff[i] = {est[i][rrmse_pkg::DATA_W-1], est[i]}
                    - {truth[i][rrmse_pkg::DATA_W-1], truth[i]};
            neg[i]  = -diff[i];
            // magnitude is at most 2^32-1, fits the low word
            o_push_data.mag[i] = diff[i][rrmse_pkg::DATA_W]
                               ? neg[i][rrmse_pkg::DATA_W-1:0]
                               : diff[i][rrmse_pkg::DATA_W-1:0];
        end
    end

    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

endmodule
`default_nettype wire

### rtl/rrmse_queue.sv
// Short FIFO of lane magnitudes between front and back.
// Depends on rrmse_pkg.
`default_nettype none
module rrmse_queue #(
    parameter int DEPTH = rrmse_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  rrmse_pkg::t_work      i_push_data,
    input  wire logic             i_pop,
    output rrmse_pkg::t_work      o_pop_data,
    output rrmse_pkg::t_q_status  o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rrmse_pkg::t_work  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_cnt,    n_cnt;
    logic              do_push, do_pop;

    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

### rtl/rrmse_back.sv
// Back end: squares, accumulates, divides by the count, takes the root.
// Depends on rrmse_pkg.
`default_nettype none
module rrmse_back #(
    parameter int COUNT_WIDTH = rrmse_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  rrmse_pkg::t_q_status                               i_q_status,
    input  rrmse_pkg::t_work                                   i_pop_data,
    output logic                                               o_pop,
    input  wire logic [rrmse_pkg::LANES-1:0][rrmse_pkg::DATA_W-1:0] i_tol,
    output logic                                               o_out_valid,
    input  wire logic                                          i_out_ready,
    output rrmse_pkg::t_out_beat                               o_out_data
);

    localparam int L  = rrmse_pkg::LANES;
    localparam int DW = rrmse_pkg::DATA_W;
    localparam int SW = rrmse_pkg::SUM_W;
    localparam int RW = DW + 1;   // root remainder width

    rrmse_pkg::t_back_state r_state, n_state;
    logic [rrmse_pkg::LANE_W-1:0] r_lane, n_lane;
    logic [rrmse_pkg::STEP_W-1:0] r_step, n_step;
    logic [COUNT_WIDTH-1:0]       r_count, n_count;
    rrmse_pkg::t_work             r_work, n_work;
    logic [SW-1:0]                r_prod, n_prod;
    logic [SW-1:0]                r_sum  [L];
    logic [SW-1:0]                n_sum  [L];
    logic [SW-1:0]                r_quo  [L];
    logic [SW-1:0]                n_quo  [L];
    logic [COUNT_WIDTH-1:0]       r_rem  [L];
    logic [COUNT_WIDTH-1:0]       n_rem  [L];
    logic [RW-1:0]                r_srem [L];
    logic [RW-1:0]                n_srem [L];
    logic [DW-1:0]                r_root [L];
    logic [DW-1:0]                n_root [L];
    logic                         r_out_valid, n_out_valid;
    rrmse_pkg::t_out_beat         r_out, n_out;

    logic [SW:0]          acc;
    logic [COUNT_WIDTH:0] dtry [L];
    logic [RW+1:0]        stry [L];
    logic [RW+1:0]        sbit [L];
    logic [L-1:0]         mask;

    always_comb begin
        n_state     = r_state;
        n_lane      = r_lane;
        n_step      = r_step;
        n_count     = r_count;
        n_work      = r_work;
        n_prod      = r_prod;
        n_sum       = r_sum;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_srem      = r_srem;
        n_root      = r_root;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_pop       = 1'b0;
        acc         = '0;
        mask        = '0;
        for (int i = 0; i < L; i++) begin
            dtry[i] = {r_rem[i], r_quo[i][SW-1]};
            stry[i] = {r_srem[i], r_quo[i][SW-1:SW-2]};
            sbit[i] = {1'b0, r_root[i], 2'b01};
        end

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            rrmse_pkg::BK_IDLE: begin
                // take a new item only once the last result has gone
                if (!i_q_status.empty && !r_out_valid) begin
                    o_pop   = 1'b1;
                    n_work  = i_pop_data;
                    n_lane  = '0;
                    if (r_count != '1) begin
                        n_count = r_count + 1'b1;
                    end
                    n_state = rrmse_pkg::BK_SQUARE;
                end
            end
            rrmse_pkg::BK_SQUARE: begin
                n_prod  = SW'(r_work.mag[r_lane]) * SW'(r_work.mag[r_lane]);
                n_state = rrmse_pkg::BK_ACCUM;
            end
            rrmse_pkg::BK_ACCUM: begin
                acc = {1'b0, r_sum[r_lane]} + {1'b0, r_prod};
                n_sum[r_lane] = acc[SW] ? '1 : acc[SW-1:0];
                n_quo[r_lane] = acc[SW] ? '1 : acc[SW-1:0];
                n_rem[r_lane] = '0;
                if (r_lane == rrmse_pkg::LANE_W'(L - 1)) begin
                    n_step  = '0;
                    n_state = rrmse_pkg::BK_DIVIDE;
                end else begin
                    n_lane  = r_lane + 1'b1;
                    n_state = rrmse_pkg::BK_SQUARE;
                end
            end
            rrmse_pkg::BK_DIVIDE: begin
                // restoring divide, one quotient bit per lane per cycle
                for (int i = 0; i < L; i++) begin
                    if (dtry[i] >= {1'b0, r_count}) begin
                        n_rem[i] = COUNT_WIDTH'(dtry[i] - {1'b0, r_count});
                        n_quo[i] = {r_quo[i][SW-2:0], 1'b1};
                    end else begin
                        n_rem[i] = dtry[i][COUNT_WIDTH-1:0];
                        n_quo[i] = {r_quo[i][SW-2:0], 1'b0};
                    end
                end
                if (r_step == rrmse_pkg::STEP_W'(rrmse_pkg::DIV_STEPS - 1)) begin
                    n_step = '0;
                    for (int i = 0; i < L; i++) begin
                        n_srem[i] = '0;
                        n_root[i] = '0;
                    end
                    n_state = rrmse_pkg::BK_ROOT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            rrmse_pkg::BK_ROOT: begin
                // digit-by-digit root, two radicand bits per step
                for (int i = 0; i < L; i++) begin
                    n_quo[i] = {r_quo[i][SW-3:0], 2'b00};
                    if (stry[i] >= sbit[i]) begin
                        n_srem[i] = RW'(stry[i] - sbit[i]);
                        n_root[i] = {r_root[i][DW-2:0], 1'b1};
                    end else begin
                        n_srem[i] = stry[i][RW-1:0];
                        n_root[i] = {r_root[i][DW-2:0], 1'b0};
                    end
                end
                if (r_step == rrmse_pkg::STEP_W'(rrmse_pkg::ROOT_STEPS - 1)) begin
                    n_state = rrmse_pkg::BK_EMIT;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            rrmse_pkg::BK_EMIT: begin
                for (int i = 0; i < L; i++) begin
                    mask[i] = (r_root[i] > i_tol[i]);
                end
                n_out.rmse_0     = r_root[0];
                n_out.rmse_1     = r_root[1];
                n_out.rmse_2     = r_root[2];
                n_out.rmse_3     = r_root[3];
                n_out.over_mask  = mask;
                n_out.step_count = DW'(r_count);
                n_out_valid      = 1'b1;
                n_state          = rrmse_pkg::BK_IDLE;
            end
            default: begin
                n_state = rrmse_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrmse_pkg::BK_IDLE;
            r_lane      <= '0;
            r_step      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < L; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_lane      <= n_lane;
            r_step      <= n_step;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_prod <= n_prod;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_srem <= n_srem;
        r_root <= n_root;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

### rtl/running_rmse_four_lanes_unit.sv
// Running RMSE over four Q16.16 lanes: tolerance registers, front, queue and back.
// Depends on rrmse_pkg, rrmse_front, rrmse_queue and rrmse_back.
//
// Each input beat carries four signed Q16.16 estimates and four ground truths.
// Per lane the block squares the difference into a saturating 64-bit sum and
// reports floor(sqrt(floor(sum / count))) as unsigned Q16.16, with a count of
// items (saturating at 2^COUNT_WIDTH-1) and a mask of lanes whose RMSE is
// strictly above the lane's tolerance register. Exactly one result beat per
// input beat, in order. Per item the back end pops it from the queue,
// squares and adds the four lanes in turn on one multiplier, runs the
// bit-serial division shared in step by all lanes, then the digit-by-digit
// root, and loads the output register. A queue of QUEUE_DEPTH items lets the
// input side keep accepting beats while the back end works, until the queue
// is full, and the output register holds a result until it is taken; the
// back end starts the next item once the output register is free.
// Tolerances are written through a plain write port (index 0..3 = lanes
// 0..3) and should be changed only while the block is idle.
`default_nettype none
module running_rmse_four_lanes_unit #(
    parameter int COUNT_WIDTH = rrmse_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = rrmse_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  rrmse_pkg::t_in_beat                    i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output rrmse_pkg::t_out_beat                   o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [rrmse_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [rrmse_pkg::DATA_W-1:0]      i_cfg_data
);

    // tolerance registers, one per lane
    logic [rrmse_pkg::LANES-1:0][rrmse_pkg::DATA_W-1:0] r_tol, n_tol;

    rrmse_pkg::t_q_status q_status;
    rrmse_pkg::t_work     push_data;
    rrmse_pkg::t_work     pop_data;
    logic                 push;
    logic                 pop;

    always_comb begin
        n_tol = r_tol;
        if (i_cfg_we) begin
            case (rrmse_pkg::t_cfg_idx'(i_cfg_idx))
                rrmse_pkg::CFG_TOL_LANE0: n_tol[0] = i_cfg_data;
                rrmse_pkg::CFG_TOL_LANE1: n_tol[1] = i_cfg_data;
                rrmse_pkg::CFG_TOL_LANE2: n_tol[2] = i_cfg_data;
                rrmse_pkg::CFG_TOL_LANE3: n_tol[3] = i_cfg_data;
                default:                  n_tol    = r_tol;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rrmse_pkg::LANES; i++) begin
                r_tol[i] <= rrmse_pkg::TOL_RESET[i];
            end
        end else begin
            r_tol <= n_tol;
        end
    end

    // front: beat in, lane magnitudes out
    rrmse_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    rrmse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    // back: accumulate, divide, root, output register
    rrmse_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_pop_data  (pop_data),
        .o_pop       (pop),
        .i_tol       (r_tol),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

### rtl/rrmse_checker.sv
// Port-level checker for the running RMSE unit, bound to the top level.
// Depends on rrmse_pkg and running_rmse_four_lanes_unit_macros.svh.
`default_nettype none
`include "running_rmse_four_lanes_unit_macros.svh"
module rrmse_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input rrmse_pkg::t_out_beat                 o_out_data
);

    // a stalled result beat holds
    `RRMSE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // every result counts at least the item that caused it
    `RRMSE_ASSERT_IMP(a_count_nonzero, i_clk, i_rst_n, o_out_valid, o_out_data.step_count != '0)

    // results are never back to back: none straight after a taken beat
    `RRMSE_ASSERT_NXT(a_out_gap, i_clk, i_rst_n, o_out_valid && i_out_ready, !o_out_valid)

endmodule

bind running_rmse_four_lanes_unit rrmse_checker u_rrmse_checker (.*);
`default_nettype wire

### bench/tb.sv
// Self-checking bench for running_rmse_four_lanes_unit: predictor, driver, checker.
// Depends on rrmse_pkg and the RTL of the unit; reads nothing else.
`default_nettype none
module tb;

    localparam int QUIET_LIMIT = 6000;   // cycles with no beat before giving up
    localparam int SETTLE      = 130;    // back end latency plus margin

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 in_ready;
    rrmse_pkg::t_in_beat  in_data;
    logic                 out_valid;
    logic                 out_ready;
    rrmse_pkg::t_out_beat out_data;
    logic                 cfg_we;
    logic [rrmse_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [rrmse_pkg::DATA_W-1:0]    cfg_data;

    running_rmse_four_lanes_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Own copy of the unit's state and tolerances
    logic [rrmse_pkg::SUM_W-1:0]  lane_sum [rrmse_pkg::LANES];
    logic [rrmse_pkg::DATA_W-1:0] beat_count;
    logic [rrmse_pkg::DATA_W-1:0] tol_copy [rrmse_pkg::LANES];

    rrmse_pkg::t_out_beat rmse_pending [$];
    int        mismatches;
    int        beats_sent;
    int        beats_checked;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_cycles;
    int        quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Floor square root, digit by digit
    function automatic logic [rrmse_pkg::DATA_W-1:0] root_floor(
            logic [rrmse_pkg::SUM_W-1:0] v);
        logic [rrmse_pkg::SUM_W-1:0] res;
        logic [rrmse_pkg::SUM_W-1:0] bitv;
        res  = '0;
        bitv = 64'h1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[rrmse_pkg::DATA_W-1:0];
    endfunction

    // Advances the state by one accepted beat and returns the expected result
    function automatic rrmse_pkg::t_out_beat advance_rmse(rrmse_pkg::t_in_beat b);
        logic signed [rrmse_pkg::DATA_W-1:0] est   [rrmse_pkg::LANES];
        logic signed [rrmse_pkg::DATA_W-1:0] truth [rrmse_pkg::LANES];
        logic signed [rrmse_pkg::DATA_W:0]   diff;
        logic [rrmse_pkg::DATA_W:0]          mag;
        logic [rrmse_pkg::SUM_W:0]           acc;
        logic [rrmse_pkg::DATA_W-1:0]        r    [rrmse_pkg::LANES];
        logic [rrmse_pkg::LANES-1:0]         mask;
        rrmse_pkg::t_out_beat                o;
        est   = '{b.est_0, b.est_1, b.est_2, b.est_3};
        truth = '{b.truth_0, b.truth_1, b.truth_2, b.truth_3};
        mask  = '0;
        if (beat_count != '1)
            beat_count = beat_count + 1;
        for (int i = 0; i < rrmse_pkg::LANES; i++) begin
            diff = $signed({est[i][rrmse_pkg::DATA_W-1], est[i]})
                 - $signed({truth[i][rrmse_pkg::DATA_W-1], truth[i]});
            mag  = diff[rrmse_pkg::DATA_W] ? -diff : diff;
            acc  = {1'b0, lane_sum[i]}
                 + ({32'd0, mag[rrmse_pkg::DATA_W-1:0]} * {32'd0, mag[rrmse_pkg::DATA_W-1:0]});
            lane_sum[i] = acc[rrmse_pkg::SUM_W] ? '1 : acc[rrmse_pkg::SUM_W-1:0];
            r[i] = root_floor(lane_sum[i] / {32'd0, beat_count});
            if (r[i] > tol_copy[i])
                mask[i] = 1'b1;
        end
        o.rmse_0     = r[0];
        o.rmse_1     = r[1];
        o.rmse_2     = r[2];
        o.rmse_3     = r[3];
        o.over_mask  = mask;
        o.step_count = beat_count;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [rrmse_pkg::DATA_W-1:0] got,
                                   logic [rrmse_pkg::DATA_W-1:0] want);
        $display("mismatch %s at beat %0d: got %h want %h", what, beats_checked, got, want);
        mismatches++;
    endtask

    // Checker and watchdog share the clock edge
    always @(posedge i_clk) begin
        rrmse_pkg::t_out_beat want;
        if (i_rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
            if (out_valid && out_ready) begin
                if (rmse_pending.size() == 0) begin
                    report_mismatch("unexpected result beat", out_data.step_count, '0);
                end else begin
                    want = rmse_pending.pop_front();
                    if (out_data.rmse_0 !== want.rmse_0)
                        report_mismatch("rmse_0", out_data.rmse_0, want.rmse_0);
                    if (out_data.rmse_1 !== want.rmse_1)
                        report_mismatch("rmse_1", out_data.rmse_1, want.rmse_1);
                    if (out_data.rmse_2 !== want.rmse_2)
                        report_mismatch("rmse_2", out_data.rmse_2, want.rmse_2);
                    if (out_data.rmse_3 !== want.rmse_3)
                        report_mismatch("rmse_3", out_data.rmse_3, want.rmse_3);
                    if (out_data.over_mask !== want.over_mask)
                        report_mismatch("over_mask", out_data.over_mask, want.over_mask);
                    if (out_data.step_count !== want.step_count)
                        report_mismatch("step_count", out_data.step_count, want.step_count);
                end
                beats_checked++;
            end
        end
    end

    // Receiver: long hold-off first, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one beat; valid stays high across back-to-back beats
    task automatic send_beat(rrmse_pkg::t_in_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        rmse_pending.push_back(advance_rmse(b));
        beats_sent++;
    endtask

    // Waits for every result, then lets the back end settle
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (rmse_pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_tol(rrmse_pkg::t_cfg_idx idx, logic [rrmse_pkg::DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        tol_copy[idx] = val;
    endtask

    task automatic set_all_tol(logic [rrmse_pkg::DATA_W-1:0] t0,
                               logic [rrmse_pkg::DATA_W-1:0] t1,
                               logic [rrmse_pkg::DATA_W-1:0] t2,
                               logic [rrmse_pkg::DATA_W-1:0] t3);
        write_tol(rrmse_pkg::CFG_TOL_LANE0, t0);
        write_tol(rrmse_pkg::CFG_TOL_LANE1, t1);
        write_tol(rrmse_pkg::CFG_TOL_LANE2, t2);
        write_tol(rrmse_pkg::CFG_TOL_LANE3, t3);
    endtask

    // Random beat with a bounded error per lane, so the sums stay meaningful
    function automatic rrmse_pkg::t_in_beat random_beat();
        logic signed [rrmse_pkg::DATA_W-1:0] t    [rrmse_pkg::LANES];
        logic signed [rrmse_pkg::DATA_W-1:0] e    [rrmse_pkg::LANES];
        longint                              span;
        longint                              delta;
        rrmse_pkg::t_in_beat                 b;
        for (int i = 0; i < rrmse_pkg::LANES; i++) begin
            t[i]  = $urandom;
            span  = longint'(1) << $urandom_range(15, 0);
            delta = longint'($urandom_range(span * 2)) - span;
            if (longint'(t[i]) + delta > 64'sd2147483647 ||
                longint'(t[i]) + delta < -64'sd2147483648)
                delta = -delta;
            e[i] = rrmse_pkg::DATA_W'(longint'(t[i]) + delta);
        end
        b = '{e[0], e[1], e[2], e[3], t[0], t[1], t[2], t[3]};
        return b;
    endfunction

    function automatic logic [rrmse_pkg::DATA_W-1:0] random_tol();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return $urandom_range(20000);
        endcase
    endfunction

    task automatic test_reset_tolerances;
        rrmse_pkg::t_in_beat b;
        // Errors straddling the reset limits, both signs
        b = '{32'sd6000, -32'sd6554, 32'sd0, -32'sd30000, 0, 0, 0, 0};
        send_beat(b);
        b = '{0, 0, 0, 0, 32'sd5898, 32'sd100, -32'sd26214, 32'sd19661};
        send_beat(b);
        drain();
    endtask

    task automatic test_directed;
        rrmse_pkg::t_in_beat b;
        set_all_tol('0, '1, 32'd1, 32'h7fff_ffff);
        // No error at the field extremes
        b = '{32'h7fff_ffff, 32'h8000_0000, 0, 32'hffff_ffff,
              32'h7fff_ffff, 32'h8000_0000, 0, 32'hffff_ffff};
        send_beat(b);
        b = '{0, 0, 0, 0, 0, 0, 0, 0};
        send_beat(b);
        // Unit and one-LSB errors
        b = '{32'sd1, -32'sd1, 32'sd65536, -32'sd65536, 0, 0, 0, 0};
        send_beat(b);
        b = '{32'h5555_5555, 32'haaaa_aaaa, 32'h0000_ffff, 32'hffff_0000,
              32'h5555_5554, 32'haaaa_aaab, 32'h0001_0000, 32'hfffe_ffff};
        send_beat(b);
        for (int i = 0; i < 6; i++)
            send_beat(random_beat());
        drain();
    endtask

    task automatic test_tolerance_sweep;
        for (int s = 0; s < 6; s++) begin
            set_all_tol(random_tol(), random_tol(), random_tol(), random_tol());
            for (int i = 0; i < 40; i++)
                send_beat(random_beat());
            drain();
        end
    endtask

    task automatic test_idle_phases;
        int send_pct [4] = '{0, 52, 0, 35};
        int recv_pct [4] = '{0, 0, 52, 35};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            set_all_tol(random_tol(), random_tol(), random_tol(), random_tol());
            for (int i = 0; i < 200; i++)
                send_beat(random_beat());
            drain();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Receiver holds off while beats keep coming, so the queue fills
    task automatic test_backpressure;
        hold_cycles = 800;
        for (int i = 0; i < 100; i++)
            send_beat(random_beat());
        drain();
    endtask

    // Full-scale errors: the lane sums run into their ceiling and stay there
    task automatic test_saturation;
        rrmse_pkg::t_in_beat b;
        set_all_tol(32'hffff_ffff, 32'hffff_fffe, 32'h0, 32'h8000_0000);
        for (int i = 0; i < 4; i++) begin
            b = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
            send_beat(b);
        end
        for (int i = 0; i < 8; i++) begin
            b = '{$urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom};
            send_beat(b);
        end
        drain();
    endtask

    initial begin
        in_valid       <= 1'b0;
        in_data        <= '0;
        out_ready      <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= '0;
        cfg_data       <= '0;
        i_rst_n        <= 1'b0;
        mismatches     = 0;
        beats_sent     = 0;
        beats_checked  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        quiet_cycles   = 0;
        beat_count     = '0;
        for (int i = 0; i < rrmse_pkg::LANES; i++) begin
            lane_sum[i] = '0;
            tol_copy[i] = rrmse_pkg::TOL_RESET[i];
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_tolerances();
        test_directed();
        test_tolerance_sweep();
        test_idle_phases();
        test_backpressure();
        test_saturation();

        if (rmse_pending.size() != 0) begin
            report_mismatch("results never arrived", '0, rmse_pending.size());
        end
        $display("covered %0d beats sent, %0d checked, %0d mismatches", beats_sent,
                 beats_checked, mismatches);
        $display("phases: reset limits, extremes, tolerance sweep, idling, hold-off, saturation");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
